// ===== rtl/ptb_pkg.sv =====
package ptb_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int UCNT_W      = $clog2(TIMER_COUNT + 1);

  localparam int FUNC_W = 3;
  localparam int ID_W   = 4;
  localparam int PER_W  = 16;
  localparam int MASK_W = 16;
  localparam int USED_W = 5;

  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STOP   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd5;

  // Command strobes broadcast to every cell; high only for an accepted transaction.
  typedef struct packed {
    logic tick;
    logic create;
    logic del;
    logic start;
    logic stop;
  } cmd_t;

  // Lowest-free search passed along the row.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] id;
  } claim_t;

  // State of the addressed timer passed along the row.
  typedef struct packed {
    logic             alloc;
    logic             run;
    logic [PER_W-1:0] rem;
  } qry_t;

endpackage

// ===== rtl/periodic_timer_bank.sv =====
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_func, in_timer_id, in_period
// out      output     out_valid, out_stall, out_fired_mask, out_new_id, out_create_ok,
//                     out_remaining, out_running, out_used_count
//
// Each transaction is worked out in the cycle it is accepted by the row of timer cells,
// and its result is held in the output register from the following cycle.
// A new transaction is taken every cycle unless a held result is stalled.
// Reset is synchronous and clears every timer and the used count.
// While the output is stalled, in_stall is high and all state holds.
module periodic_timer_bank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ptb_pkg::FUNC_W-1:0]  in_func,
  input  logic [ptb_pkg::ID_W-1:0]    in_timer_id,
  input  logic [ptb_pkg::PER_W-1:0]   in_period,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ptb_pkg::MASK_W-1:0]  out_fired_mask,
  output logic [ptb_pkg::ID_W-1:0]    out_new_id,
  output logic                        out_create_ok,
  output logic [ptb_pkg::PER_W-1:0]   out_remaining,
  output logic                        out_running,
  output logic [ptb_pkg::USED_W-1:0]  out_used_count
);
  import ptb_pkg::*;

  logic                   accept;
  cmd_t                   cmd;
  logic                   is_query;
  logic [TIMER_COUNT-1:0] sel;
  logic [TIMER_COUNT-1:0] fire;
  claim_t                 claim [TIMER_COUNT+1];
  qry_t                   qry   [TIMER_COUNT+1];
  logic [MASK_W-1:0]      mask;
  logic [UCNT_W-1:0]      ucnt_r, ucnt_nxt;

  logic                   out_valid_r;
  logic [MASK_W-1:0]      mask_r;
  logic [ID_W-1:0]        new_id_r;
  logic                   ok_r;
  logic [PER_W-1:0]       rem_r;
  logic                   run_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd      = '0;
    is_query = 1'b0;
    case (in_func)
      FN_TICK:   cmd.tick   = accept;
      FN_CREATE: cmd.create = accept;
      FN_DELETE: cmd.del    = accept;
      FN_START:  cmd.start  = accept;
      FN_STOP:   cmd.stop   = accept;
      FN_QUERY:  is_query   = 1'b1;
      default:   cmd        = '0;
    endcase
  end

  assign claim[0] = '0;
  assign qry[0]   = '0;

  for (genvar k = 0; k < TIMER_COUNT; k++) begin : g_cell
    assign sel[k] = (32'(in_timer_id) == k);
    ptb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel[k]),
      .period    (in_period),
      .cell_idx  (IDX_W'(k)),
      .claim_in  (claim[k]),
      .claim_out (claim[k+1]),
      .qry_in    (qry[k]),
      .qry_out   (qry[k+1]),
      .fire      (fire[k])
    );
  end

  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < TIMER_COUNT) begin : g_bit
      assign mask[b] = fire[b];
    end else begin : g_zero
      assign mask[b] = 1'b0;
    end
  end

  // The used count is kept incrementally rather than summed over the cells.
  always_comb begin
    ucnt_nxt = ucnt_r;
    if (cmd.create && claim[TIMER_COUNT].found) begin
      ucnt_nxt = ucnt_r + UCNT_W'(1);
    end else if (cmd.del && qry[TIMER_COUNT].alloc) begin
      ucnt_nxt = ucnt_r - UCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ucnt_r <= ucnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r   <= cmd.tick ? mask : '0;
      ok_r     <= cmd.create && claim[TIMER_COUNT].found;
      new_id_r <= (cmd.create && claim[TIMER_COUNT].found) ?
                  ID_W'(claim[TIMER_COUNT].id) : '0;
      rem_r    <= is_query ? qry[TIMER_COUNT].rem : '0;
      run_r    <= is_query && qry[TIMER_COUNT].run;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_mask = mask_r;
  assign out_new_id     = new_id_r;
  assign out_create_ok  = ok_r;
  assign out_remaining  = rem_r;
  assign out_running    = run_r;
  assign out_used_count = USED_W'(ucnt_r);

endmodule

// ===== rtl/ptb_cell.sv =====
module ptb_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptb_pkg::cmd_t              cmd,
  input  logic                       sel,
  input  logic [ptb_pkg::PER_W-1:0]  period,
  input  logic [ptb_pkg::IDX_W-1:0]  cell_idx,
  input  ptb_pkg::claim_t            claim_in,
  output ptb_pkg::claim_t            claim_out,
  input  ptb_pkg::qry_t              qry_in,
  output ptb_pkg::qry_t              qry_out,
  output logic                       fire
);
  import ptb_pkg::*;

  logic             alloc_r, alloc_nxt;
  logic [PER_W-1:0] per_r, per_nxt;
  logic [PER_W-1:0] cnt_r, cnt_nxt;
  logic [PER_W-1:0] dec;
  logic             running;
  logic             take;

  assign running = alloc_r && (per_r != '0);
  assign dec     = cnt_r - PER_W'(1);
  assign take    = !claim_in.found && !alloc_r;

  assign claim_out.found = claim_in.found || !alloc_r;
  assign claim_out.id    = take ? cell_idx : claim_in.id;

  always_comb begin
    if (sel) begin
      qry_out.alloc = alloc_r;
      qry_out.run   = running;
      qry_out.rem   = running ? cnt_r : '0;
    end else begin
      qry_out = qry_in;
    end
  end

  always_comb begin
    alloc_nxt = alloc_r;
    per_nxt   = per_r;
    cnt_nxt   = cnt_r;
    fire      = 1'b0;
    if (cmd.tick && running) begin
      if (dec == '0) begin
        cnt_nxt = per_r;
        fire    = 1'b1;
      end else begin
        cnt_nxt = dec;
      end
    end
    if (cmd.create && take) begin
      alloc_nxt = 1'b1;
      per_nxt   = '0;
      cnt_nxt   = '0;
    end
    if (cmd.del && sel) begin
      alloc_nxt = 1'b0;
      per_nxt   = '0;
      cnt_nxt   = '0;
    end
    if (cmd.start && sel && alloc_r) begin
      per_nxt = period;
      cnt_nxt = period;
    end
    if (cmd.stop && sel) begin
      per_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= 1'b0;
      per_r   <= '0;
      cnt_r   <= '0;
    end else begin
      alloc_r <= alloc_nxt;
      per_r   <= per_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== tb/sv/timer_bank_checker.sv =====
module timer_bank_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [ptb_pkg::FUNC_W-1:0] in_func,
  input  logic [ptb_pkg::ID_W-1:0]   in_timer_id,
  input  logic [ptb_pkg::PER_W-1:0]  in_period,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [ptb_pkg::MASK_W-1:0] out_fired_mask,
  input  logic [ptb_pkg::ID_W-1:0]   out_new_id,
  input  logic                       out_create_ok,
  input  logic [ptb_pkg::PER_W-1:0]  out_remaining,
  input  logic                       out_running,
  input  logic [ptb_pkg::USED_W-1:0] out_used_count,
  output int                         mismatch_count,
  output int                         outstanding
);
  import ptb_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic [ID_W-1:0]   new_id;
    logic              create_ok;
    logic [PER_W-1:0]  remaining;
    logic              running;
    logic [USED_W-1:0] used_count;
  } timer_result_t;

  // Shadow copy of the timer bank.
  logic             alloc_q  [TIMER_COUNT];
  logic [PER_W-1:0] reload_q [TIMER_COUNT];
  logic [PER_W-1:0] count_q  [TIMER_COUNT];

  timer_result_t expected_results[$];
  timer_result_t got;
  timer_result_t want;

  function automatic timer_result_t apply_command(input logic [FUNC_W-1:0] f,
                                                  input logic [ID_W-1:0]   id,
                                                  input logic [PER_W-1:0]  per);
    timer_result_t r;
    bit            hit;
    int            used;
    r    = '0;
    hit  = (id < TIMER_COUNT);
    used = 0;
    case (f)
      FN_TICK: begin
        for (int k = 0; k < TIMER_COUNT; k++) begin
          if (alloc_q[k] && reload_q[k] != '0) begin
            count_q[k] = count_q[k] - 1'b1;
            if (count_q[k] == '0) begin
              count_q[k] = reload_q[k];
              if (k < MASK_W) r.fired_mask[k] = 1'b1;
            end
          end
        end
      end
      FN_CREATE: begin
        for (int k = 0; k < TIMER_COUNT; k++) begin
          if (!alloc_q[k] && !r.create_ok) begin
            alloc_q[k]  = 1'b1;
            reload_q[k] = '0;
            count_q[k]  = '0;
            r.new_id    = ID_W'(k);
            r.create_ok = 1'b1;
          end
        end
      end
      FN_DELETE: begin
        if (hit) begin
          alloc_q[id]  = 1'b0;
          reload_q[id] = '0;
          count_q[id]  = '0;
        end
      end
      FN_START: begin
        if (hit && alloc_q[id]) begin
          reload_q[id] = per;
          count_q[id]  = per;
        end
      end
      FN_STOP: begin
        if (hit) begin
          reload_q[id] = '0;
          count_q[id]  = '0;
        end
      end
      FN_QUERY: begin
        if (hit && alloc_q[id] && reload_q[id] != '0) begin
          r.remaining = count_q[id];
          r.running   = 1'b1;
        end
      end
      default: begin
      end
    endcase
    for (int k = 0; k < TIMER_COUNT; k++) used += alloc_q[k];
    r.used_count = USED_W'(used);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input timer_result_t w, input timer_result_t g);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s at %0t: expected fired=%h new_id=%0d ok=%b rem=%0d run=%b used=%0d",
               what, $time, w.fired_mask, w.new_id, w.create_ok, w.remaining, w.running,
               w.used_count);
      $display("    actual   fired=%h new_id=%0d ok=%b rem=%0d run=%b used=%0d",
               g.fired_mask, g.new_id, g.create_ok, g.remaining, g.running, g.used_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TIMER_COUNT; k++) begin
        alloc_q[k]  = 1'b0;
        reload_q[k] = '0;
        count_q[k]  = '0;
      end
      expected_results.delete();
      mismatch_count = 0;
      outstanding    = 0;
    end else begin
      // The result register is loaded at acceptance and read from the next cycle, so the output is checked
      // before this edge's input transaction is predicted.
      if (out_valid && !out_stall) begin
        got = '{out_fired_mask, out_new_id, out_create_ok, out_remaining, out_running,
                out_used_count};
        if (expected_results.size() == 0) begin
          log_mismatch("Unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.fired_mask !== want.fired_mask || got.new_id !== want.new_id ||
              got.create_ok !== want.create_ok || got.remaining !== want.remaining ||
              got.running !== want.running || got.used_count !== want.used_count) begin
            log_mismatch("Mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(in_func, in_timer_id, in_period));
      end
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import ptb_pkg::*;

  // Function codes the block does not implement.
  localparam logic [FUNC_W-1:0] FN_RESERVED_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RESERVED_B = 3'd7;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                PHASE_ITEMS   = 480;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func     = '0;
  logic [ID_W-1:0]   in_timer_id = '0;
  logic [PER_W-1:0]  in_period   = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [MASK_W-1:0] out_fired_mask;
  logic [ID_W-1:0]   out_new_id;
  logic              out_create_ok;
  logic [PER_W-1:0]  out_remaining;
  logic              out_running;
  logic [USED_W-1:0] out_used_count;

  int mismatch_count;
  int outstanding;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int func_counts[8];

  periodic_timer_bank uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_timer_id    (in_timer_id),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fired_mask (out_fired_mask),
    .out_new_id     (out_new_id),
    .out_create_ok  (out_create_ok),
    .out_remaining  (out_remaining),
    .out_running    (out_running),
    .out_used_count (out_used_count)
  );

  timer_bank_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_timer_id    (in_timer_id),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fired_mask (out_fired_mask),
    .out_new_id     (out_new_id),
    .out_create_ok  (out_create_ok),
    .out_remaining  (out_remaining),
    .out_running    (out_running),
    .out_used_count (out_used_count),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // A long hold-off, once requested, overrides the random stall pattern.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                           input logic [PER_W-1:0] per);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_timer_id <= id;
    in_period   <= per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    func_counts[f]++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Short periods dominate so that timers expire often within a phase.
  function automatic logic [PER_W-1:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 60) return PER_W'($urandom_range(4, 1));
    if (r < 80) return PER_W'($urandom_range(40, 5));
    if (r < 90) return PER_W'($urandom);
    if (r < 95) return '1;
    return PER_W'(1);
  endfunction

  // create_w and delete_w together make up 27 of every hundred commands.
  function automatic logic [FUNC_W-1:0] pick_func(input int create_w, input int delete_w);
    int r;
    r = $urandom_range(99);
    if (r < 34) return FN_TICK;
    if (r < 34 + create_w) return FN_CREATE;
    if (r < 34 + create_w + delete_w) return FN_DELETE;
    if (r < 77) return FN_START;
    if (r < 82) return FN_STOP;
    if (r < 96) return FN_QUERY;
    return $urandom_range(1) ? FN_RESERVED_A : FN_RESERVED_B;
  endfunction

  task automatic run_phase(input int send_idle, input int recv_stall, input int create_w,
                           input bit long_hold);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (long_hold && i == PHASE_ITEMS / 2) hold_left = HOLD_CYCLES;
      send_item(pick_func(create_w, 27 - create_w), ID_W'($urandom_range(15)), pick_period());
    end
    wait_for_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(FN_CREATE, 4'd0, '0);
    send_item(FN_CREATE, 4'd9, '1);
    send_item(FN_CREATE, 4'd0, '0);
    send_item(FN_START, 4'd0, 16'd1);
    send_item(FN_START, 4'd1, 16'hFFFF);
    send_item(FN_START, 4'd2, 16'd0);
    send_item(FN_TICK, 4'd0, '0);
    send_item(FN_TICK, 4'd15, '1);
    send_item(FN_QUERY, 4'd0, '0);
    send_item(FN_QUERY, 4'd1, '0);
    send_item(FN_QUERY, 4'd2, '0);
    send_item(FN_STOP, 4'd1, '0);
    send_item(FN_QUERY, 4'd1, '0);
    send_item(FN_DELETE, 4'd0, '0);
    // Start and stop on a timer that is no longer allocated.
    send_item(FN_START, 4'd0, 16'd5);
    send_item(FN_STOP, 4'd0, '0);
    send_item(FN_QUERY, 4'd0, '0);
    send_item(FN_RESERVED_A, 4'd15, '1);
    send_item(FN_RESERVED_B, 4'd0, '0);
    send_item(FN_TICK, 4'd0, '0);
    send_item(FN_DELETE, 4'd15, '0);
    wait_for_results();

    run_phase(0, 0, 20, 1'b1);
    run_phase(64, 0, 14, 1'b0);
    run_phase(0, 64, 7, 1'b0);
    run_phase(7, 7, 14, 1'b0);

    stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("Covered %0d transactions: %0d tick, %0d create, %0d delete, %0d start,",
             func_counts.sum(), func_counts[FN_TICK], func_counts[FN_CREATE],
             func_counts[FN_DELETE], func_counts[FN_START]);
    $display("  %0d stop, %0d query, %0d reserved; %0d-cycle output hold, %0d mismatches.",
             func_counts[FN_STOP], func_counts[FN_QUERY],
             func_counts[FN_RESERVED_A] + func_counts[FN_RESERVED_B], HOLD_CYCLES,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("periodic_timer_bank: match");
    end else begin
      $display("periodic_timer_bank: mismatch");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Timed out with %0d results outstanding.", outstanding);
    $display("periodic_timer_bank: mismatch");
    $finish;
  end

endmodule
